/* hw/rtl/bqjd_pkg.sv */
// Shared constants, types and helper functions of the bounded queue job dispatcher.
`timescale 1ns / 1ps
`default_nettype none

package bqjd_pkg;

  localparam int MAX_SERVERS = 32;
  localparam int MAX_DEPTH   = 16;
  localparam int TIME_BITS   = 20;

  localparam int SRV_W  = $clog2(MAX_SERVERS);
  localparam int SLOT_W = $clog2(MAX_DEPTH);
  localparam int NS_W   = SRV_W + 1;
  localparam int CAP_W  = SLOT_W + 1;
  localparam int FILL_W = $clog2(MAX_SERVERS * MAX_DEPTH) + 1;
  localparam int ADDR_W = SRV_W + SLOT_W;

  localparam int SVC_W      = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [TIME_BITS-1:0] TIME_MAX    = '1;
  localparam logic [TIME_BITS-1:0] CLOSE_RESET = TIME_BITS'(540);

  // Remainder unit: wide runs take the whole dividend, narrow runs only a queue slot.
  localparam int DIV_W            = FILL_W;
  localparam int DIV_CNT_W        = $clog2(DIV_W + 1);
  localparam int DIV_WIDE_STEPS   = DIV_W;
  localparam int DIV_NARROW_STEPS = SLOT_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_SERVERS   = 2'd0,
    CFG_LINE_CAPACITY = 2'd1,
    CFG_CLOSE_TIME    = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV_SRV,
    ST_TAIL_START,
    ST_SCAN,
    ST_DIV_HEAD,
    ST_DIV_TAIL,
    ST_WRITE,
    ST_READ,
    ST_UPDATE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic              start;
    logic              narrow;
    logic [DIV_W-1:0]  dividend;
    logic [NS_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [NS_W-1:0] remainder;
  } div_rsp_t;

  function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                   input logic [TIME_BITS-1:0] b);
    logic [TIME_BITS:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/bqjd_divider.sv */
// Bit-serial restoring remainder unit shared by the dispatcher sequencer.
`timescale 1ns / 1ps
`default_nettype none

module bqjd_divider (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire bqjd_pkg::div_req_t req_i,
  output bqjd_pkg::div_rsp_t      rsp_o
);

  logic                               busy_q;
  logic                               done_q;
  logic [bqjd_pkg::DIV_CNT_W-1:0]     cnt_q;
  logic [bqjd_pkg::DIV_W-1:0]         dvd_q;
  logic [bqjd_pkg::NS_W-1:0]          dvs_q;
  logic [bqjd_pkg::NS_W-1:0]          rem_q;
  logic [bqjd_pkg::NS_W:0]            trial;
  logic [bqjd_pkg::NS_W:0]            diff;
  logic [bqjd_pkg::NS_W-1:0]          rem_d;

  // One quotient bit per cycle: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    trial = {rem_q, dvd_q[bqjd_pkg::DIV_W-1]};
    diff  = trial - {1'b0, dvs_q};
    rem_d = (trial >= {1'b0, dvs_q}) ? diff[bqjd_pkg::NS_W-1:0] : trial[bqjd_pkg::NS_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.narrow ? bqjd_pkg::DIV_CNT_W'(bqjd_pkg::DIV_NARROW_STEPS)
                               : bqjd_pkg::DIV_CNT_W'(bqjd_pkg::DIV_WIDE_STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == bqjd_pkg::DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      dvs_q <= req_i.divisor;
      if (req_i.narrow) begin
        dvd_q <= {req_i.dividend[bqjd_pkg::SLOT_W-1:0],
                  {(bqjd_pkg::DIV_W - bqjd_pkg::SLOT_W){1'b0}}};
      end else begin
        dvd_q <= req_i.dividend;
      end
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[bqjd_pkg::DIV_W-2:0], 1'b0};
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.remainder = rem_q;

endmodule

`default_nettype wire

/* hw/rtl/bounded_queue_job_dispatcher.sv */
// Top level of the bounded queue job dispatcher: sequencer, server state and queue memory.
`timescale 1ns / 1ps
`default_nettype none

// Each input item carries one job's service time and a restart flag. The block assigns the
// job to a server and returns one result item holding the finish time, the server index and
// a late flag. While the queues are still filling, jobs go round robin; afterwards each job
// goes to the server whose head job finishes earliest, lowest index on ties.
// Both channels use valid and ready. The input is ready only while the sequencer is idle, so
// one job is in work at a time. A fill-phase job runs a 10-step remainder for the
// round-robin server and a 4-step slot remainder. A later job runs a linear scan of
// the head finish times, one server per cycle, then two 4-step slot remainders and a queue
// memory write and read. The next item can be accepted in the cycle after a result is
// loaded. All remainders run one bit per cycle on a single shared unit.
// The result sits in an output register; the next item is accepted while it waits, and that
// item's work stalls in its last step until the receiver takes the pending result.
// Reset clears all server times, queue pointers and the fill counter and loads the register
// defaults; the queue memory is not cleared: with unchanged registers, slots are written
// before read. A restart item clears the same state when accepted, keeping the registers.
// Configuration writes take effect at once and are meant only while the block is idle.

module bounded_queue_job_dispatcher (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [bqjd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [bqjd_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [bqjd_pkg::SVC_W-1:0]      service_time_i,
  input  wire logic                            restart_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [bqjd_pkg::TIME_BITS-1:0]       finish_time_o,
  output logic [bqjd_pkg::SRV_W-1:0]           server_index_o,
  output logic                                 late_o
);

  localparam int TB = bqjd_pkg::TIME_BITS;
  localparam int SW = bqjd_pkg::SRV_W;
  localparam int LW = bqjd_pkg::SLOT_W;

  // Configuration registers.
  logic [bqjd_pkg::NS_W-1:0]  num_servers_q;
  logic [bqjd_pkg::CAP_W-1:0] line_capacity_q;
  logic [TB-1:0]              close_time_q;

  // Server state, held in flip-flops so that reset and restart clear it at once.
  logic [TB-1:0]               end_time_q  [bqjd_pkg::MAX_SERVERS];
  logic [TB-1:0]               head_done_q [bqjd_pkg::MAX_SERVERS];
  logic [LW-1:0]               head_ptr_q  [bqjd_pkg::MAX_SERVERS];
  logic [LW-1:0]               tail_ptr_q  [bqjd_pkg::MAX_SERVERS];
  logic [bqjd_pkg::FILL_W-1:0] fill_count_q;

  // Queue memory: one row of slots per server.
  logic [bqjd_pkg::SVC_W-1:0] qmem [bqjd_pkg::MAX_SERVERS * bqjd_pkg::MAX_DEPTH];
  logic [bqjd_pkg::SVC_W-1:0] rd_q;

  bqjd_pkg::state_e   state_q, state_d;
  bqjd_pkg::div_req_t div_req;
  bqjd_pkg::div_rsp_t div_rsp;

  // Work registers of the job in hand.
  logic [bqjd_pkg::SVC_W-1:0] svc_q;
  logic [SW-1:0]              srv_q;
  logic [TB-1:0]              min_q;
  logic [bqjd_pkg::NS_W-1:0]  scan_idx_q;
  logic [LW-1:0]              head_q;
  logic [LW-1:0]              tail_q;
  logic [TB-1:0]              fin_q;
  logic                       late_q;
  logic                       fill_q;
  logic                       round0_q;

  // Output register.
  logic          out_valid_q;
  logic [TB-1:0] out_fin_q;
  logic [SW-1:0] out_srv_q;
  logic          out_late_q;

  logic [bqjd_pkg::NS_W-1:0]            ns_eff;
  logic [bqjd_pkg::CAP_W-1:0]           cap_eff;
  logic [bqjd_pkg::NS_W+bqjd_pkg::CAP_W-1:0] fill_lim;
  logic                                 in_fill;
  logic                                 accept;
  logic                                 load_out;
  logic                                 scan_end;
  logic [TB-1:0]                        scan_val;
  logic [TB-1:0]                        end_sum;
  logic [LW-1:0]                        rem_slot;
  logic [LW-1:0]                        rem_next;
  logic [LW-1:0]                        tail_next;

  // Slot after x in a ring of cap_eff slots, for x already below cap_eff.
  function automatic logic [LW-1:0] wrap_inc(input logic [LW-1:0]             x,
                                             input logic [bqjd_pkg::CAP_W-1:0] cap);
    logic [bqjd_pkg::CAP_W-1:0] nxt;
    nxt = {1'b0, x} + 1'b1;
    return (nxt == cap) ? '0 : nxt[LW-1:0];
  endfunction

  // Out-of-range register values act as the nearest legal value.
  always_comb begin
    if (num_servers_q == '0) begin
      ns_eff = bqjd_pkg::NS_W'(1);
    end else if (num_servers_q > bqjd_pkg::NS_W'(bqjd_pkg::MAX_SERVERS)) begin
      ns_eff = bqjd_pkg::NS_W'(bqjd_pkg::MAX_SERVERS);
    end else begin
      ns_eff = num_servers_q;
    end
    if (line_capacity_q == '0) begin
      cap_eff = bqjd_pkg::CAP_W'(1);
    end else if (line_capacity_q > bqjd_pkg::CAP_W'(bqjd_pkg::MAX_DEPTH)) begin
      cap_eff = bqjd_pkg::CAP_W'(bqjd_pkg::MAX_DEPTH);
    end else begin
      cap_eff = line_capacity_q;
    end
  end

  assign fill_lim  = {{bqjd_pkg::CAP_W{1'b0}}, ns_eff} * {{bqjd_pkg::NS_W{1'b0}}, cap_eff};
  assign in_fill   = {{(bqjd_pkg::NS_W + bqjd_pkg::CAP_W - bqjd_pkg::FILL_W){1'b0}},
                      fill_count_q} < fill_lim;
  assign accept    = in_valid_i && in_ready_o;
  assign scan_end  = (scan_idx_q == ns_eff);
  assign scan_val  = head_done_q[scan_idx_q[SW-1:0]];
  assign end_sum   = bqjd_pkg::sat_add(end_time_q[srv_q], TB'(svc_q));
  assign rem_slot  = div_rsp.remainder[LW-1:0];
  assign rem_next  = wrap_inc(rem_slot, cap_eff);
  assign tail_next = wrap_inc(tail_q, cap_eff);

  bqjd_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Sequencer state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bqjd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and the requests to the shared remainder unit.
  always_comb begin
    state_d         = state_q;
    load_out        = 1'b0;
    div_req.start   = 1'b0;
    div_req.narrow  = 1'b1;
    div_req.dividend = bqjd_pkg::DIV_W'(tail_ptr_q[srv_q]);
    div_req.divisor = {1'b0, cap_eff};
    case (state_q)
      bqjd_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = bqjd_pkg::ST_CHECK;
        end
      end
      bqjd_pkg::ST_CHECK: begin
        if (in_fill) begin
          // Round-robin server is the fill count modulo the server count.
          div_req.start    = 1'b1;
          div_req.narrow   = 1'b0;
          div_req.dividend = fill_count_q;
          div_req.divisor  = ns_eff;
          state_d          = bqjd_pkg::ST_DIV_SRV;
        end else begin
          state_d = bqjd_pkg::ST_SCAN;
        end
      end
      bqjd_pkg::ST_DIV_SRV: begin
        if (div_rsp.done) begin
          state_d = bqjd_pkg::ST_TAIL_START;
        end
      end
      bqjd_pkg::ST_TAIL_START: begin
        div_req.start = 1'b1;
        state_d       = bqjd_pkg::ST_DIV_TAIL;
      end
      bqjd_pkg::ST_SCAN: begin
        if (scan_end) begin
          div_req.start    = 1'b1;
          div_req.dividend = bqjd_pkg::DIV_W'(head_ptr_q[srv_q]);
          state_d          = bqjd_pkg::ST_DIV_HEAD;
        end
      end
      bqjd_pkg::ST_DIV_HEAD: begin
        if (div_rsp.done) begin
          div_req.start = 1'b1;
          state_d       = bqjd_pkg::ST_DIV_TAIL;
        end
      end
      bqjd_pkg::ST_DIV_TAIL: begin
        if (div_rsp.done) begin
          state_d = bqjd_pkg::ST_WRITE;
        end
      end
      bqjd_pkg::ST_WRITE: begin
        state_d = fill_q ? bqjd_pkg::ST_DONE : bqjd_pkg::ST_READ;
      end
      bqjd_pkg::ST_READ: begin
        state_d = bqjd_pkg::ST_UPDATE;
      end
      bqjd_pkg::ST_UPDATE: begin
        state_d = bqjd_pkg::ST_DONE;
      end
      bqjd_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = bqjd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bqjd_pkg::ST_IDLE;
      end
    endcase
  end

  // Configuration writes; an index past the register list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_servers_q   <= bqjd_pkg::NS_W'(1);
      line_capacity_q <= bqjd_pkg::CAP_W'(1);
      close_time_q    <= bqjd_pkg::CLOSE_RESET;
    end else if (cfg_we_i) begin
      case (bqjd_pkg::cfg_idx_e'(cfg_index_i))
        bqjd_pkg::CFG_NUM_SERVERS:   num_servers_q   <= cfg_wdata_i[bqjd_pkg::NS_W-1:0];
        bqjd_pkg::CFG_LINE_CAPACITY: line_capacity_q <= cfg_wdata_i[bqjd_pkg::CAP_W-1:0];
        bqjd_pkg::CFG_CLOSE_TIME:    close_time_q    <= cfg_wdata_i[TB-1:0];
        default: begin
        end
      endcase
    end
  end

  // Server times, queue pointers and the fill counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < bqjd_pkg::MAX_SERVERS; i++) begin
        end_time_q[i]  <= '0;
        head_done_q[i] <= '0;
        head_ptr_q[i]  <= '0;
        tail_ptr_q[i]  <= '0;
      end
      fill_count_q <= '0;
    end else begin
      if (accept && restart_i) begin
        for (int i = 0; i < bqjd_pkg::MAX_SERVERS; i++) begin
          end_time_q[i]  <= '0;
          head_done_q[i] <= '0;
          head_ptr_q[i]  <= '0;
          tail_ptr_q[i]  <= '0;
        end
        fill_count_q <= '0;
      end
      if (state_q == bqjd_pkg::ST_WRITE) begin
        tail_ptr_q[srv_q] <= tail_next;
        end_time_q[srv_q] <= end_sum;
        if (fill_q) begin
          fill_count_q <= fill_count_q + 1'b1;
          // In the first round the new job is also the server's head.
          if (round0_q) begin
            head_done_q[srv_q] <= end_sum;
          end
        end else begin
          head_ptr_q[srv_q] <= head_q;
        end
      end
      if (state_q == bqjd_pkg::ST_UPDATE) begin
        head_done_q[srv_q] <= bqjd_pkg::sat_add(min_q, TB'(rd_q));
      end
    end
  end

  // Queue memory: the new job is written in the cycle before the new head is read, so a
  // single-slot queue reads back the job just written.
  always_ff @(posedge clk_i) begin
    if (state_q == bqjd_pkg::ST_WRITE) begin
      qmem[{srv_q, tail_q}] <= svc_q;
    end
    if (state_q == bqjd_pkg::ST_READ) begin
      rd_q <= qmem[{srv_q, head_q}];
    end
  end

  // Work registers of the job in hand.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      svc_q <= service_time_i;
    end
    case (state_q)
      bqjd_pkg::ST_CHECK: begin
        fill_q     <= in_fill;
        round0_q   <= fill_count_q < bqjd_pkg::FILL_W'(ns_eff);
        srv_q      <= '0;
        min_q      <= head_done_q[0];
        scan_idx_q <= bqjd_pkg::NS_W'(1);
      end
      bqjd_pkg::ST_DIV_SRV: begin
        if (div_rsp.done) begin
          srv_q <= div_rsp.remainder[SW-1:0];
        end
      end
      bqjd_pkg::ST_SCAN: begin
        // Strict compare keeps the lowest index on equal head times.
        if (!scan_end) begin
          if (scan_val < min_q) begin
            min_q <= scan_val;
            srv_q <= scan_idx_q[SW-1:0];
          end
          scan_idx_q <= scan_idx_q + 1'b1;
        end
      end
      bqjd_pkg::ST_DIV_HEAD: begin
        if (div_rsp.done) begin
          head_q <= rem_next;
        end
      end
      bqjd_pkg::ST_DIV_TAIL: begin
        if (div_rsp.done) begin
          tail_q <= rem_slot;
        end
      end
      bqjd_pkg::ST_WRITE: begin
        late_q <= end_time_q[srv_q] >= close_time_q;
        fin_q  <= end_sum;
      end
      default: begin
      end
    endcase
  end

  // Output register: a pending result is held until the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_fin_q  <= fin_q;
      out_srv_q  <= srv_q;
      out_late_q <= late_q;
    end
  end

  assign in_ready_o     = (state_q == bqjd_pkg::ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign finish_time_o  = out_fin_q;
  assign server_index_o = out_srv_q;
  assign late_o         = out_late_q;

endmodule

`default_nettype wire

/* bench/tb_bounded_queue_job_dispatcher.sv */
// Testbench of the bounded queue job dispatcher: directed and random jobs checked by a scoreboard.
`timescale 1ns / 1ps

module tb_bounded_queue_job_dispatcher;
  import bqjd_pkg::*;

  localparam int HALF_PERIOD    = 6;
  localparam int RESET_CYCLES   = 11;
  // Neither channel moving for this many cycles means the block has hung. The slowest
  // legal gap is a full server scan plus a long receiver stall, well under this.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 100;
  localparam int MODE_SPAN      = 60;
  localparam int BUSY_PCT       = 45;
  localparam int LIGHT_PCT      = 7;
  localparam int RANDOM_PHASES  = 6;
  localparam int FILL_JOB_CAP   = 64;
  localparam int LONG_RUN_JOBS  = 1060;
  localparam int EDGE_RESTART_AT = 9;
  localparam logic [SVC_W-1:0] EDGE_TIMES [6] = '{1023, 1, 0, 512, 1023, 1};

  typedef enum {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_e;
  typedef enum {JOBS_EDGE, JOBS_MIXED, JOBS_LONG} job_mix_e;

  typedef struct packed {
    logic [TIME_BITS-1:0] finish_time;
    logic [SRV_W-1:0]     server;
    logic                 late;
  } job_outcome_t;

  // The scoreboard keeps its own copy of the registers, the server times and the
  // queues, works out the outcome of every accepted job and holds the outcomes
  // in arrival order until the matching result item comes out of the block.
  class dispatch_tracker;
    logic [NS_W-1:0]      servers_reg;
    logic [CAP_W-1:0]     depth_reg;
    logic [TIME_BITS-1:0] close_reg;
    logic [TIME_BITS-1:0] end_time [MAX_SERVERS];
    logic [TIME_BITS-1:0] head_done [MAX_SERVERS];
    logic [SVC_W-1:0]     slot_svc [MAX_SERVERS][MAX_DEPTH];
    bit                   slot_used [MAX_SERVERS][MAX_DEPTH];
    int unsigned          head_ptr [MAX_SERVERS];
    int unsigned          tail_ptr [MAX_SERVERS];
    int unsigned          placed;
    job_outcome_t         due_results [$];
    int unsigned          jobs_seen, restarts, late_seen, ceiling_hits, mismatches;

    function new();
      servers_reg = 1;
      depth_reg   = 1;
      close_reg   = CLOSE_RESET;
      foreach (slot_used[s, d]) slot_used[s][d] = 1'b0;
      clear_queues();
      jobs_seen    = 0;
      restarts     = 0;
      late_seen    = 0;
      ceiling_hits = 0;
      mismatches   = 0;
    endfunction

    function void clear_queues();
      foreach (end_time[s]) begin
        end_time[s]  = '0;
        head_done[s] = '0;
        head_ptr[s]  = 0;
        tail_ptr[s]  = 0;
      end
      placed = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_NUM_SERVERS:   servers_reg = data[NS_W-1:0];
        CFG_LINE_CAPACITY: depth_reg   = data[CAP_W-1:0];
        CFG_CLOSE_TIME:    close_reg   = data[TIME_BITS-1:0];
        default: ;
      endcase
    endfunction

    // Out-of-range register values are pulled into the legal range.
    function int unsigned active_servers();
      if (servers_reg == 0) return 1;
      return (servers_reg > MAX_SERVERS) ? MAX_SERVERS : int'(servers_reg);
    endfunction

    function int unsigned active_depth();
      if (depth_reg == 0) return 1;
      return (depth_reg > MAX_DEPTH) ? MAX_DEPTH : int'(depth_reg);
    endfunction

    function logic [TIME_BITS-1:0] add_ticks(logic [TIME_BITS-1:0] base,
                                             logic [TIME_BITS-1:0] ticks);
      longint total;
      total = longint'(base) + longint'(ticks);
      return (total > longint'(TIME_MAX)) ? TIME_MAX : total[TIME_BITS-1:0];
    endfunction

    function bit in_fill();
      return placed < active_servers() * active_depth();
    endfunction

    function int unsigned earliest_server();
      int unsigned best;
      best = 0;
      for (int unsigned i = 1; i < active_servers(); i++)
        if (head_done[i] < head_done[best]) best = i;
      return best;
    endfunction

    // True when a job without restart would pop onto a queue slot never written.
    function bit reads_blank_slot();
      int unsigned srv, depth, head;
      if (in_fill()) return 1'b0;
      depth = active_depth();
      srv   = earliest_server();
      head  = (head_ptr[srv] % depth + 1) % depth;
      return !slot_used[srv][head] && head != tail_ptr[srv] % depth;
    endfunction

    function void note_job(logic [SVC_W-1:0] svc, logic restart);
      int unsigned srv, depth, head, tail, round;
      job_outcome_t outcome;
      jobs_seen++;
      if (restart) begin
        clear_queues();
        restarts++;
      end
      depth = active_depth();
      if (in_fill()) begin
        round = placed / active_servers();
        srv   = placed % active_servers();
        tail  = tail_ptr[srv] % depth;
        slot_svc[srv][tail]  = svc;
        slot_used[srv][tail] = 1'b1;
        tail_ptr[srv] = (tail + 1) % depth;
        outcome.late  = end_time[srv] >= close_reg;
        end_time[srv] = add_ticks(end_time[srv], TIME_BITS'(svc));
        if (round == 0) head_done[srv] = end_time[srv];
        placed++;
      end else begin
        srv  = earliest_server();
        head = (head_ptr[srv] % depth + 1) % depth;
        head_ptr[srv] = head;
        tail = tail_ptr[srv] % depth;
        slot_svc[srv][tail]  = svc;
        slot_used[srv][tail] = 1'b1;
        tail_ptr[srv]  = (tail + 1) % depth;
        head_done[srv] = add_ticks(head_done[srv], TIME_BITS'(slot_svc[srv][head]));
        outcome.late   = end_time[srv] >= close_reg;
        end_time[srv]  = add_ticks(end_time[srv], TIME_BITS'(svc));
      end
      outcome.finish_time = end_time[srv];
      outcome.server      = SRV_W'(srv);
      due_results.push_back(outcome);
    endfunction

    function void check_result(logic [TIME_BITS-1:0] finish, logic [SRV_W-1:0] server,
                               logic late);
      job_outcome_t want;
      if (due_results.size() == 0) begin
        $error("result item with no job outstanding: finish_time %0d, server_index %0d",
               finish, server);
        mismatches++;
        return;
      end
      want = due_results.pop_front();
      if (finish !== want.finish_time) begin
        $error("finish_time: expected %0d, got %0d", want.finish_time, finish);
        mismatches++;
      end
      if (server !== want.server) begin
        $error("server_index: expected %0d, got %0d", want.server, server);
        mismatches++;
      end
      if (late !== want.late) begin
        $error("late: expected %0d, got %0d", want.late, late);
        mismatches++;
      end
      if (want.late) late_seen++;
      if (want.finish_time == TIME_MAX) ceiling_hits++;
    endfunction
  endclass

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i    = '0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_ready_o;
  logic [SVC_W-1:0]      service_time_i = '0;
  logic                  restart_i      = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i    = 1'b0;
  logic [TIME_BITS-1:0]  finish_time_o;
  logic [SRV_W-1:0]      server_index_o;
  logic                  late_o;

  dispatch_tracker tracker = new();
  int source_idle_pct = 0;
  int sink_stall_pct  = 0;
  int jobs_sent       = 0;
  int settings_used   = 0;
  int quiet_cycles    = 0;

  bounded_queue_job_dispatcher u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .service_time_i (service_time_i),
    .restart_i      (restart_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .finish_time_o  (finish_time_o),
    .server_index_o (server_index_o),
    .late_o         (late_o)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Result side: the handshake is judged on the values settled before the edge,
  // and the ready for the next cycle is then drawn from the current stall rate.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      tracker.check_result(finish_time_o, server_index_o, late_o);
    out_ready_i <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // Watchdog: counts cycles in which neither channel moves an item.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("bounded_queue_job_dispatcher test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Writes all three registers on consecutive edges, keeping the write enable
  // high throughout. The unused upper data bits of the narrow registers carry
  // random noise, which the block must ignore.
  task automatic program_regs(input int unsigned servers, input int unsigned depth,
                              input int unsigned close_at);
    cfg_idx_e              idx;
    logic [CFG_DATA_W-1:0] data;
    idx = CFG_NUM_SERVERS;
    repeat (3) begin
      case (idx)
        CFG_NUM_SERVERS:   data = CFG_DATA_W'({$urandom, NS_W'(servers)});
        CFG_LINE_CAPACITY: data = CFG_DATA_W'({$urandom, CAP_W'(depth)});
        default:           data = CFG_DATA_W'(close_at);
      endcase
      cfg_we_i    <= 1'b1;
      cfg_index_i <= idx;
      cfg_wdata_i <= data;
      @(posedge clk_i);
      tracker.write_reg(idx, data);
      idx = idx.next();
    end
    cfg_we_i <= 1'b0;
  endtask

  // Offers one job. The idling pattern changes every few dozen items, so that
  // gaps and stalls fall on every stage of the block's work. Called at an edge;
  // returns at the edge where the item was accepted, with valid still high.
  task automatic drive_job(input logic [SVC_W-1:0] svc, input logic restart);
    idle_mode_e mode;
    mode = idle_mode_e'((jobs_sent / MODE_SPAN) % 4);
    case (mode)
      IDLE_SRC: begin
        source_idle_pct = BUSY_PCT;
        sink_stall_pct  = 0;
      end
      IDLE_SNK: begin
        source_idle_pct = 0;
        sink_stall_pct  = BUSY_PCT;
      end
      IDLE_BOTH: begin
        source_idle_pct = LIGHT_PCT;
        sink_stall_pct  = LIGHT_PCT;
      end
      default: begin
        source_idle_pct = 0;
        sink_stall_pct  = 0;
      end
    endcase
    while ($urandom_range(0, 99) < source_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    service_time_i <= svc;
    restart_i      <= restart;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_job(svc, restart);
    jobs_sent++;
  endtask

  // One phase: wait until every outstanding result has come back, so that the
  // block is idle, program the registers, then send the jobs. A mixed phase
  // adds as many jobs as the queues hold, at most FILL_JOB_CAP, so that with
  // small queues most jobs reach the earliest-finish dispatch. A job that would
  // pop a never written queue slot without restart is sent with restart set.
  task automatic run_phase(input int unsigned servers, input int unsigned depth,
                           input int unsigned close_at, input int unsigned jobs,
                           input job_mix_e mix);
    logic [SVC_W-1:0] svc;
    logic             restart;
    int unsigned      total;
    while (tracker.due_results.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
    program_regs(servers, depth, close_at);
    settings_used++;
    total = jobs;
    if (mix == JOBS_MIXED) begin
      total += (tracker.active_servers() * tracker.active_depth() > FILL_JOB_CAP) ?
               FILL_JOB_CAP : tracker.active_servers() * tracker.active_depth();
    end
    for (int unsigned j = 0; j < total; j++) begin
      case (mix)
        JOBS_EDGE: begin
          svc     = EDGE_TIMES[j % 6];
          restart = (j == EDGE_RESTART_AT);
        end
        JOBS_LONG: begin
          svc     = SVC_W'($urandom_range(1000, 1023));
          restart = 1'b0;
        end
        default: begin
          case ($urandom_range(0, 19))
            0:       svc = '0;
            1:       svc = '1;
            2:       svc = SVC_W'(1);
            default: svc = SVC_W'($urandom_range(1, 1023));
          endcase
          restart = ($urandom_range(0, 49) == 0);
        end
      endcase
      if (tracker.reads_blank_slot()) restart = 1'b1;
      drive_job(svc, restart);
    end
    in_valid_i <= 1'b0;
  endtask

  initial begin
    int unsigned servers, depth, close_at;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Three servers of depth two with a closing time of zero, so
    // every job is late; extreme service times including zero, the fill and the
    // dispatch stages, and a restart part way through. Then zero register values,
    // which act as one, with the latest closing time, and register values above
    // the maximum, which act as the maximum and resume the fill on the new servers.
    run_phase(3, 2, 0, 12, JOBS_EDGE);
    run_phase(0, 0, TIME_MAX, 4, JOBS_EDGE);
    run_phase(63, 31, CLOSE_RESET, 4, JOBS_EDGE);

    // Random phases, mostly with few servers and short queues so that the
    // queues fill quickly; now and then the largest or out-of-range settings.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: servers = $urandom_range(1, 6);
        6:                servers = MAX_SERVERS;
        7:                servers = 0;
        8:                servers = $urandom_range(MAX_SERVERS + 1, 63);
        default:          servers = $urandom_range(7, MAX_SERVERS - 1);
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: depth = $urandom_range(1, 4);
        6:                depth = MAX_DEPTH;
        7:                depth = 0;
        8:                depth = $urandom_range(MAX_DEPTH + 1, 31);
        default:          depth = $urandom_range(5, MAX_DEPTH - 1);
      endcase
      case ($urandom_range(0, 5))
        0:       close_at = 0;
        1:       close_at = TIME_MAX;
        default: close_at = $urandom_range(0, 12000);
      endcase
      run_phase(servers, depth, close_at, $urandom_range(10, 30), JOBS_MIXED);
    end

    // A long run on a single server with near-maximal service times drives the
    // server's end time into the ceiling; with the latest closing time the late
    // flag rises only once the ceiling is reached.
    run_phase($urandom_range(0, 1), $urandom_range(1, MAX_DEPTH), TIME_MAX, LONG_RUN_JOBS,
              JOBS_LONG);

    while (tracker.due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d jobs under %0d register settings, %0d of them with restart.",
             tracker.jobs_seen, settings_used, tracker.restarts);
    $display("%0d results were late, %0d reached the finish-time ceiling, %0d mismatches.",
             tracker.late_seen, tracker.ceiling_hits, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.due_results.size() == 0) begin
      $display("bounded_queue_job_dispatcher test passed");
    end else begin
      $display("bounded_queue_job_dispatcher test failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/bqjd_pkg.sv
hw/rtl/bqjd_divider.sv
hw/rtl/bounded_queue_job_dispatcher.sv
bench/tb_bounded_queue_job_dispatcher.sv
